// ===== hw/rtl/atl_pkg.sv =====
`default_nettype none
package atl_pkg;

  localparam int ADC_BITS_DEF        = 10;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int NUM_AXES            = 3;
  localparam int ACC_W               = 16;
  localparam int CAL_W               = 15;
  localparam int CFG_IDX_W           = 3;
  localparam int RAW_AT_MIN          = 662;
  localparam int RAW_AT_MAX          = 355;
  localparam int ROOT_W              = 32;
  localparam int ROOT_STEPS          = 32;
  localparam int NORM_STEPS          = 5;
  localparam int CORDIC_STEPS        = 30;
  localparam int ANG_W               = 33;

  // angle lanes
  localparam int LANE_PITCH = 0;
  localparam int LANE_ROLL  = 1;
  localparam int LANE_THETA = 2;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [CAL_W-1:0] cal_t;
  typedef logic [ROOT_W-1:0]       root_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X = 3'd0,
    CFG_MAX_X = 3'd1,
    CFG_MIN_Y = 3'd2,
    CFG_MAX_Y = 3'd3,
    CFG_MIN_Z = 3'd4,
    CFG_MAX_Z = 3'd5
  } cfg_idx_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:       v = 33'sd843314857;
      1:       v = 33'sd497837829;
      2:       v = 33'sd263043837;
      3:       v = 33'sd133525159;
      4:       v = 33'sd67021687;
      5:       v = 33'sd33543516;
      6:       v = 33'sd16775851;
      7:       v = 33'sd8388437;
      8:       v = 33'sd4194283;
      9:       v = 33'sd2097149;
      default: v = ANG_W'(64'd1 << (30 - i));
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/atl_calib.sv =====
`default_nettype none
module atl_calib #(
  parameter int ADC_BITS = atl_pkg::ADC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [ADC_BITS-1:0] raw [atl_pkg::NUM_AXES],
  input  wire atl_pkg::cal_t      cal_lo [atl_pkg::NUM_AXES],
  input  wire atl_pkg::cal_t      cal_hi [atl_pkg::NUM_AXES],
  output logic                    out_valid,
  output atl_pkg::acc_t           acc [atl_pkg::NUM_AXES]
);
  import atl_pkg::*;

  localparam int RW  = ((ADC_BITS > 10) ? ADC_BITS : 10) + 1;
  localparam int DW  = RW + CAL_W + 1;
  localparam int DIV = RAW_AT_MIN - RAW_AT_MAX;
  localparam logic [63:0]   RECIP_FULL = (64'd1 << DW) / 64'(DIV);
  localparam logic [DW-1:0] RECIP      = RECIP_FULL[DW-1:0];
  localparam logic signed [DW+1:0] SAT_HI = (DW+2)'(32767);
  localparam logic signed [DW+1:0] SAT_LO = (DW+2)'(-32768);

  logic v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    logic signed [RW-1:0]   rd;
    logic signed [CAL_W:0]  span;
    logic [DW-1:0]          ad;
    logic [2*DW-1:0]        qprod;
    logic [DW-1:0]          rem;
    logic [DW-1:0]          q;
    logic signed [DW+1:0]   g;
    acc_t                   sat;

    logic signed [DW-1:0]   d_r;
    cal_t                   lo1_r, lo2_r;
    logic [DW-1:0]          ad_r, q0_r;
    logic                   neg_r;
    acc_t                   acc_r;

    always_comb begin
      rd    = $signed(RW'(raw[ax])) - $signed(RW'(RAW_AT_MIN));
      span  = $signed({cal_hi[ax][CAL_W-1], cal_hi[ax]}) -
              $signed({cal_lo[ax][CAL_W-1], cal_lo[ax]});
      ad    = d_r[DW-1] ? DW'(-d_r) : DW'(d_r);
      qprod = (2*DW)'(ad) * (2*DW)'(RECIP);
      // reciprocal estimate is low by at most one
      rem   = ad_r - DW'(q0_r * DW'(DIV));
      q     = q0_r + DW'(rem >= DW'(DIV));
      // divisor is negative: quotient sign flips
      g     = neg_r ? $signed({2'b00, q}) : -$signed({2'b00, q});
      g     = g + (DW+2)'(lo2_r);
      if (g > SAT_HI)      sat = acc_t'(SAT_HI);
      else if (g < SAT_LO) sat = acc_t'(SAT_LO);
      else                 sat = acc_t'(g);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r   <= DW'(rd) * DW'(span);
        lo1_r <= cal_lo[ax];
        ad_r  <= ad;
        q0_r  <= qprod[2*DW-1:DW];
        neg_r <= d_r[DW-1];
        lo2_r <= lo1_r;
        acc_r <= sat;
      end
    end

    assign acc[ax] = acc_r;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/atl_isqrt.sv =====
`default_nettype none
module atl_isqrt (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire atl_pkg::acc_t acc_i [atl_pkg::NUM_AXES],
  output logic               out_valid,
  output atl_pkg::acc_t      acc_o [atl_pkg::NUM_AXES],
  output atl_pkg::root_t     root [atl_pkg::NUM_AXES]
);
  import atl_pkg::*;

  localparam int PW = NUM_AXES * ACC_W;

  logic          vld_r [ROOT_STEPS+1];
  logic [PW-1:0] pay_r [ROOT_STEPS+1];
  logic [PW-1:0] pay_in;
  logic [31:0]   sq [NUM_AXES];
  logic [31:0]   sum [NUM_AXES];

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      pay_in[ax*ACC_W +: ACC_W] = acc_i[ax];
      sq[ax] = 32'(acc_i[ax] * acc_i[ax]);
    end
    sum[LANE_PITCH] = sq[1] + sq[2];
    sum[LANE_ROLL]  = sq[0] + sq[2];
    sum[LANE_THETA] = sq[0] + sq[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= ROOT_STEPS; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 0; k < ROOT_STEPS; k++) vld_r[k+1] <= vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= pay_in;
      for (int k = 0; k < ROOT_STEPS; k++) pay_r[k+1] <= pay_r[k];
    end
  end

  for (genvar ln = 0; ln < NUM_AXES; ln++) begin : g_lane
    logic [63:0] v_r [ROOT_STEPS+1];
    logic [63:0] r_r [ROOT_STEPS+1];
    logic [63:0] v_nxt [ROOT_STEPS];
    logic [63:0] r_nxt [ROOT_STEPS];

    // one result bit per stage, radicand is sum * 2^32
    always_comb begin
      logic [63:0] b;
      logic [64:0] t;
      for (int k = 0; k < ROOT_STEPS; k++) begin
        b = 64'd1 << (62 - 2*k);
        t = {1'b0, r_r[k]} + {1'b0, b};
        if ({1'b0, v_r[k]} >= t) begin
          v_nxt[k] = v_r[k] - t[63:0];
          r_nxt[k] = (r_r[k] >> 1) + b;
        end else begin
          v_nxt[k] = v_r[k];
          r_nxt[k] = r_r[k] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[0] <= {sum[ln], 32'd0};
        r_r[0] <= 64'd0;
        for (int k = 0; k < ROOT_STEPS; k++) begin
          v_r[k+1] <= v_nxt[k];
          r_r[k+1] <= r_nxt[k];
        end
      end
    end

    assign root[ln]  = r_r[ROOT_STEPS][ROOT_W-1:0];
    assign acc_o[ln] = pay_r[ROOT_STEPS][ln*ACC_W +: ACC_W];
  end

  assign out_valid = vld_r[ROOT_STEPS];

endmodule
`default_nettype wire

// ===== hw/rtl/atl_cordic.sv =====
`default_nettype none
module atl_cordic #(
  parameter int ANGLE_FRAC_BITS = atl_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire atl_pkg::acc_t  acc_i [atl_pkg::NUM_AXES],
  input  wire atl_pkg::root_t root [atl_pkg::NUM_AXES],
  output logic                out_valid,
  output atl_pkg::acc_t       acc_o [atl_pkg::NUM_AXES],
  output atl_pkg::acc_t       angle [atl_pkg::NUM_AXES]
);
  import atl_pkg::*;

  localparam int F    = ANGLE_FRAC_BITS;
  localparam int PW   = NUM_AXES * ACC_W;
  localparam int LAST = 1 + NORM_STEPS + CORDIC_STEPS + 2;
  localparam int CS0  = 1 + NORM_STEPS;
  localparam int XW   = 36;
  localparam int P1W  = 42;
  localparam int TW   = P1W - 30 + F + 1;
  localparam int P2W  = TW + 32;
  localparam int MW   = TW - 3;
  localparam logic [31:0]   DIV10 = 32'hCCCCCCCD;
  localparam logic [MW-1:0] CAP   = MW'(90) << F;

  // flags: {neg, num zero, den zero}
  logic          vld_r [LAST+1];
  logic [PW-1:0] pay_r [LAST+1];
  logic [PW-1:0] pay_in;
  logic [16:0]   mag_in [NUM_AXES];

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      pay_in[ax*ACC_W +: ACC_W] = acc_i[ax];
      mag_in[ax] = acc_i[ax][ACC_W-1] ? 17'(-{acc_i[ax][ACC_W-1], acc_i[ax]})
                                      : 17'({1'b0, acc_i[ax]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LAST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 0; s < LAST; s++) vld_r[s+1] <= vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= pay_in;
      for (int s = 0; s < LAST; s++) pay_r[s+1] <= pay_r[s];
    end
  end

  for (genvar ln = 0; ln < NUM_AXES; ln++) begin : g_lane
    logic [31:0]              num, den;
    logic                     neg;
    logic [2:0]               flg_r [LAST];
    logic [31:0]              n_r [NORM_STEPS+1];
    logic [31:0]              d_r [NORM_STEPS+1];
    logic [31:0]              n_nxt [NORM_STEPS];
    logic [31:0]              d_nxt [NORM_STEPS];
    logic signed [XW-1:0]     x_r [CORDIC_STEPS];
    logic signed [XW-1:0]     y_r [CORDIC_STEPS];
    logic signed [ANG_W-1:0]  a_r [CORDIC_STEPS];
    logic signed [XW-1:0]     x_nxt [CORDIC_STEPS];
    logic signed [XW-1:0]     y_nxt [CORDIC_STEPS];
    logic signed [ANG_W-1:0]  a_nxt [CORDIC_STEPS];
    logic [P1W-1:0]           p1_r;
    logic [P2W-1:0]           p2_r;
    logic [P1W-1:0]           p1;
    logic [TW-1:0]            t;
    logic [MW-1:0]            mag;
    logic signed [MW:0]       sang;
    acc_t                     ang_r;

    always_comb begin
      if (ln == LANE_PITCH) begin
        num = {mag_in[0][15:0], 16'd0};
        den = root[LANE_PITCH];
        neg = acc_i[0][ACC_W-1];
      end else if (ln == LANE_ROLL) begin
        num = {mag_in[1][15:0], 16'd0};
        den = root[LANE_ROLL];
        neg = acc_i[1][ACC_W-1];
      end else begin
        num = root[LANE_THETA];
        den = {mag_in[2][15:0], 16'd0};
        neg = acc_i[2][ACC_W-1];
      end
      // magnitude bit 16 is lost by the 16-bit shift: force 2^31 instead
      if (ln != LANE_THETA && mag_in[ln][16]) num = 32'h8000_0000;
      if (ln == LANE_THETA && mag_in[2][16])  den = 32'h8000_0000;
    end

    // binary search normalization: shift both until the larger reaches bit 30
    always_comb begin
      int unsigned k;
      for (int j = 0; j < NORM_STEPS; j++) begin
        k = 16 >> j;
        if ((n_r[j] | d_r[j]) < (32'd1 << (31 - k))) begin
          n_nxt[j] = n_r[j] << k;
          d_nxt[j] = d_r[j] << k;
        end else begin
          n_nxt[j] = n_r[j];
          d_nxt[j] = d_r[j];
        end
      end
    end

    // vectoring steps
    always_comb begin
      logic signed [XW-1:0]    xi, yi;
      logic signed [ANG_W-1:0] ai;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (i == 0) begin
          xi = XW'({4'b0, d_r[NORM_STEPS]});
          yi = XW'({4'b0, n_r[NORM_STEPS]});
          ai = '0;
        end else begin
          xi = x_r[i-1];
          yi = y_r[i-1];
          ai = a_r[i-1];
        end
        if (!yi[XW-1]) begin
          x_nxt[i] = xi + (yi >>> i);
          y_nxt[i] = yi - (xi >>> i);
          a_nxt[i] = ai + atan_q30(i);
        end else begin
          x_nxt[i] = xi - (yi >>> i);
          y_nxt[i] = yi + (xi >>> i);
          a_nxt[i] = ai - atan_q30(i);
        end
      end
    end

    always_comb begin
      logic [31:0] ap;
      ap = a_r[CORDIC_STEPS-1][ANG_W-1] ? 32'd0 : a_r[CORDIC_STEPS-1][31:0];
      p1 = P1W'(ap) * P1W'(573);
      // floor(x / 2^(30-F)) + 5, then divide by ten via reciprocal
      t  = TW'(p1_r >> (30 - F)) + TW'(5);
      mag = MW'(p2_r >> 35);
      if (mag > CAP) mag = CAP;
      if (flg_r[LAST-1][1])      sang = '0;
      else begin
        if (flg_r[LAST-1][0]) mag = CAP;
        sang = flg_r[LAST-1][2] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flg_r[0] <= {neg, num == 32'd0, den == 32'd0};
        for (int s = 0; s < LAST - 1; s++) flg_r[s+1] <= flg_r[s];
        n_r[0] <= num;
        d_r[0] <= den;
        for (int j = 0; j < NORM_STEPS; j++) begin
          n_r[j+1] <= n_nxt[j];
          d_r[j+1] <= d_nxt[j];
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          x_r[i] <= x_nxt[i];
          y_r[i] <= y_nxt[i];
          a_r[i] <= a_nxt[i];
        end
        p1_r  <= p1;
        p2_r  <= P2W'(t) * P2W'(DIV10);
        ang_r <= ACC_W'(sang);
      end
    end

    assign angle[ln] = ang_r;
    assign acc_o[ln] = pay_r[LAST][ln*ACC_W +: ACC_W];
  end

  assign out_valid = vld_r[LAST];

endmodule
`default_nettype wire

// ===== hw/rtl/accel_tilt_angles.sv =====
`default_nettype none
// Pipeline from an accepted input word to its output word:
// 3 calibration, 33 square root, 39 normalize / CORDIC / scaling stages.
// Throughput: one word per cycle; a stalled output word freezes every stage.
// Reset (rst_n low, synchronous) empties the pipeline and sets the
// calibration registers to min -1000 mg and max 1000 mg on each axis.
module accel_tilt_angles #(
  parameter int ADC_BITS        = atl_pkg::ADC_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = atl_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // raw_x, raw_y, raw_z, zero pad
  input  wire logic [((3*ADC_BITS+7)/8)*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // accel_x_mg, accel_y_mg, accel_z_mg, pitch_angle, roll_angle, theta_angle
  output logic [6*atl_pkg::ACC_W-1:0] out_tdata,
  input  wire logic cfg_we,
  input  wire logic [atl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [atl_pkg::CAL_W-1:0] cfg_wdata
);
  import atl_pkg::*;

  cal_t cal_lo_r [NUM_AXES];
  cal_t cal_hi_r [NUM_AXES];

  logic                en;
  logic [ADC_BITS-1:0] raw [NUM_AXES];
  logic                cal_vld, rt_vld, out_vld;
  acc_t                acc_c [NUM_AXES];
  acc_t                acc_s [NUM_AXES];
  acc_t                acc_o [NUM_AXES];
  root_t               root [NUM_AXES];
  acc_t                ang [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        cal_lo_r[ax] <= cal_t'(-1000);
        cal_hi_r[ax] <= cal_t'(1000);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_X: cal_lo_r[0] <= cfg_wdata;
        CFG_MAX_X: cal_hi_r[0] <= cfg_wdata;
        CFG_MIN_Y: cal_lo_r[1] <= cfg_wdata;
        CFG_MAX_Y: cal_hi_r[1] <= cfg_wdata;
        CFG_MIN_Z: cal_lo_r[2] <= cfg_wdata;
        CFG_MAX_Z: cal_hi_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output word is held
  assign en        = !out_vld || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) raw[ax] = in_tdata[ax*ADC_BITS +: ADC_BITS];
  end

  atl_calib #(.ADC_BITS(ADC_BITS)) u_calib (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .raw       (raw),
    .cal_lo    (cal_lo_r),
    .cal_hi    (cal_hi_r),
    .out_valid (cal_vld),
    .acc       (acc_c)
  );

  atl_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cal_vld),
    .acc_i     (acc_c),
    .out_valid (rt_vld),
    .acc_o     (acc_s),
    .root      (root)
  );

  atl_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rt_vld),
    .acc_i     (acc_s),
    .root      (root),
    .out_valid (out_vld),
    .acc_o     (acc_o),
    .angle     (ang)
  );

  assign out_tvalid = out_vld;
  assign out_tdata  = {ang[2], ang[1], ang[0], acc_o[2], acc_o[1], acc_o[0]};

endmodule
`default_nettype wire
